// ===== rtl/utfww_pkg.sv =====
package utfww_pkg;

   localparam int TEXT_BYTES  = 4096;
   localparam int POS_W       = 13;
   localparam int COL_W       = 9;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_W  = 3;
   localparam int FIFO_CNT_W  = 4;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] WIDTH_RESET  = 8'd40;

   typedef struct packed {
      logic [POS_W-1:0] line_number;
      logic [POS_W-1:0] line_start;
      logic [POS_W-1:0] line_bytes;
      logic             final_line;
      logic             last_of_item;
   } record_type;

   typedef struct packed {
      logic [1:0] count;
      record_type rec0;
      record_type rec1;
   } push_type;

   // byte span of a UTF-8 character from its lead byte
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd1;
      if (b[7] == 1'b0) begin
         len = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end
      return len;
   endfunction

endpackage

// ===== rtl/utfww_core.sv =====
module utfww_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  logic [7:0]              text_byte,
   input  logic [7:0]              line_width,
   output utfww_pkg::push_type     push
);

   logic [utfww_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [utfww_pkg::POS_W-1:0] start_ff, start_in;
   logic [utfww_pkg::POS_W-1:0] bytes_ff, bytes_in;
   logic [utfww_pkg::COL_W-1:0] cols_ff, cols_in;
   logic                        space_ff, space_in;
   logic [utfww_pkg::POS_W-1:0] space_end_ff, space_end_in;
   logic [utfww_pkg::COL_W-1:0] after_ff, after_in;
   logic [1:0]                  cont_ff, cont_in;
   logic [utfww_pkg::POS_W-1:0] line_ff, line_in;

   always_comb begin
      utfww_pkg::record_type      rec_a;
      utfww_pkg::record_type      rec_f;
      logic                       a_valid;
      logic                       f_valid;
      logic                       done;
      logic [2:0]                 len;
      logic [1:0]                 cw;
      logic [utfww_pkg::POS_W:0]  reach;
      logic [utfww_pkg::COL_W:0]  need;

      pos_in       = pos_ff;
      start_in     = start_ff;
      bytes_in     = bytes_ff;
      cols_in      = cols_ff;
      space_in     = space_ff;
      space_end_in = space_end_ff;
      after_in     = after_ff;
      cont_in      = cont_ff;
      line_in      = line_ff;
      rec_a        = '0;
      rec_f        = '0;
      a_valid      = 1'b0;
      f_valid      = 1'b0;
      done         = 1'b0;
      len          = 3'd1;
      cw           = 2'd1;
      reach        = '0;
      need         = '0;
      push         = '0;

      if (item_valid) begin
         if (cont_ff != 2'd0) begin
            cont_in = cont_ff - 2'd1;
         end else if (text_byte == utfww_pkg::CHAR_NUL) begin
            // end of text: report open line and clear
            f_valid            = 1'b1;
            rec_f.line_number  = line_ff;
            rec_f.line_start   = start_ff;
            rec_f.line_bytes   = bytes_ff;
            rec_f.final_line   = 1'b1;
            done               = 1'b1;
         end else if (text_byte == utfww_pkg::CHAR_NEWLINE) begin
            a_valid           = 1'b1;
            rec_a.line_number = line_ff;
            rec_a.line_start  = start_ff;
            rec_a.line_bytes  = bytes_ff + 1'b1;
            line_in           = line_ff + 1'b1;
            start_in          = pos_ff + 1'b1;
            bytes_in          = '0;
            cols_in           = '0;
            space_in          = 1'b0;
            space_end_in      = '0;
            after_in          = '0;
         end else begin
            len   = utfww_pkg::lead_length(text_byte);
            reach = {1'b0, pos_ff} + (utfww_pkg::POS_W+1)'(len);
            // truncated character at end of buffer counts as one byte
            if (reach > (utfww_pkg::POS_W+1)'(utfww_pkg::TEXT_BYTES)) begin
               len = 3'd1;
            end
            cw   = (len >= 3'd2) ? 2'd2 : 2'd1;
            need = {1'b0, cols_ff} + (utfww_pkg::COL_W+1)'(cw);
            if (bytes_ff != '0 && need > (utfww_pkg::COL_W+1)'(line_width)) begin
               a_valid           = 1'b1;
               rec_a.line_number = line_ff;
               rec_a.line_start  = start_ff;
               if (space_ff) begin
                  // word wrap: break just after the last space
                  rec_a.line_bytes = space_end_ff;
                  start_in         = start_ff + space_end_ff;
                  bytes_in         = bytes_ff - space_end_ff;
                  cols_in          = after_ff;
               end else begin
                  rec_a.line_bytes = bytes_ff;
                  start_in         = pos_ff;
                  bytes_in         = '0;
                  cols_in          = '0;
               end
               line_in      = line_ff + 1'b1;
               space_in     = 1'b0;
               space_end_in = '0;
               after_in     = '0;
            end
            bytes_in = bytes_in + utfww_pkg::POS_W'(len);
            cols_in  = cols_in + utfww_pkg::COL_W'(cw);
            if (space_in) begin
               after_in = after_in + utfww_pkg::COL_W'(cw);
            end
            if (text_byte == utfww_pkg::CHAR_SPACE) begin
               space_in     = 1'b1;
               space_end_in = bytes_in;
               after_in     = '0;
            end
            cont_in = 2'(len - 3'd1);
         end

         if (!done) begin
            pos_in = pos_ff + 1'b1;
            if (pos_in >= utfww_pkg::POS_W'(utfww_pkg::TEXT_BYTES)) begin
               f_valid           = 1'b1;
               rec_f.line_number = line_in;
               rec_f.line_start  = start_in;
               rec_f.line_bytes  = bytes_in;
               rec_f.final_line  = 1'b1;
               done              = 1'b1;
            end
         end

         if (done) begin
            pos_in       = '0;
            start_in     = '0;
            bytes_in     = '0;
            cols_in      = '0;
            space_in     = 1'b0;
            space_end_in = '0;
            after_in     = '0;
            cont_in      = '0;
            line_in      = '0;
         end

         // order records and flag the last one of this word
         if (a_valid) begin
            push.rec0 = rec_a;
            push.rec1 = rec_f;
            if (f_valid) begin
               push.count             = 2'd2;
               push.rec1.last_of_item = 1'b1;
            end else begin
               push.count             = 2'd1;
               push.rec0.last_of_item = 1'b1;
            end
         end else if (f_valid) begin
            push.count             = 2'd1;
            push.rec0              = rec_f;
            push.rec0.last_of_item = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         start_ff     <= '0;
         bytes_ff     <= '0;
         cols_ff      <= '0;
         space_ff     <= 1'b0;
         space_end_ff <= '0;
         after_ff     <= '0;
         cont_ff      <= '0;
         line_ff      <= '0;
      end else begin
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         bytes_ff     <= bytes_in;
         cols_ff      <= cols_in;
         space_ff     <= space_in;
         space_end_ff <= space_end_in;
         after_ff     <= after_in;
         cont_ff      <= cont_in;
         line_ff      <= line_in;
      end
   end

endmodule

// ===== rtl/utfww_fifo.sv =====
module utfww_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  utfww_pkg::push_type                 push,
   input  logic                                pop,
   output logic                                not_empty,
   output utfww_pkg::record_type               head,
   output logic [utfww_pkg::FIFO_CNT_W-1:0]    level
);

   utfww_pkg::record_type mem_ff [utfww_pkg::FIFO_DEPTH];

   logic [utfww_pkg::FIFO_PTR_W-1:0] wr_ff, wr_in;
   logic [utfww_pkg::FIFO_PTR_W-1:0] rd_ff, rd_in;
   logic [utfww_pkg::FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic [utfww_pkg::FIFO_PTR_W-1:0] wr_next;
   logic                             do_pop;

   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];
   assign level     = cnt_ff;
   assign do_pop    = pop && not_empty;
   assign wr_next   = wr_ff + 1'b1;

   always_comb begin
      wr_in  = wr_ff + utfww_pkg::FIFO_PTR_W'(push.count);
      rd_in  = rd_ff + utfww_pkg::FIFO_PTR_W'(do_pop);
      cnt_in = cnt_ff + utfww_pkg::FIFO_CNT_W'(push.count)
             - utfww_pkg::FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.rec0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/utf8_word_wrap_line_splitter.sv =====
// UTF-8 word-wrap line splitter.
// The req channel carries one text byte per word (req_text_byte). The rsp
// channel returns line records: line number, start offset, byte length,
// final_line on the record that closes a text pass, and last_of_item on the
// last record caused by one byte. A byte causes zero, one or two records.
// csr_write_enable/csr_write_data set the line width in display columns;
// write it only while the block is idle.
// A taken byte is registered in the input stage, processed by the core
// from that register, and its records are written into the output queue,
// which drives the rsp channel.
// Throughput: one byte per cycle while req_ready is high; the wrap state is
// computed from the input register and registered. Bytes that yield two
// records need two transfers on rsp, absorbed by the 8-entry record queue.
// req_ready drops when the queue holds more than four records, so a stall
// on rsp backs up into req with no record lost.
// Reset clears all line state, empties the queue and sets the width to 40.
module utf8_word_wrap_line_splitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [12:0] rsp_line_number,
   output logic [12:0] rsp_line_start,
   output logic [12:0] rsp_line_bytes,
   output logic        rsp_final_line,
   output logic        rsp_last_of_item,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic                                  stage_valid_ff;
   logic [7:0]                            stage_byte_ff;
   logic [7:0]                            width_ff;
   utfww_pkg::push_type                   push;
   utfww_pkg::record_type                 head;
   logic [utfww_pkg::FIFO_CNT_W-1:0]      level;

   // room for the staged word and one more, two records each
   assign req_ready = (level <= utfww_pkg::FIFO_CNT_W'(utfww_pkg::FIFO_DEPTH - 4));

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         width_ff       <= utfww_pkg::WIDTH_RESET;
      end else begin
         stage_valid_ff <= req_valid && req_ready;
         if (csr_write_enable) begin
            width_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_byte_ff <= req_text_byte;
      end
   end

   utfww_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (stage_valid_ff),
      .text_byte  (stage_byte_ff),
      .line_width (width_ff),
      .push       (push)
   );

   utfww_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_ready),
      .not_empty (rsp_valid),
      .head      (head),
      .level     (level)
   );

   assign rsp_line_number  = head.line_number;
   assign rsp_line_start   = head.line_start;
   assign rsp_line_bytes   = head.line_bytes;
   assign rsp_final_line   = head.final_line;
   assign rsp_last_of_item = head.last_of_item;

endmodule

// ===== sim/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD    = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [12:0] rsp_line_number;
   logic [12:0] rsp_line_start;
   logic [12:0] rsp_line_bytes;
   logic        rsp_final_line;
   logic        rsp_last_of_item;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = 8'd0;

   // bytes waiting to be offered, and line records waiting to come back
   logic [7:0]             text_queue[$];
   utfww_pkg::record_type  line_records_due[$];

   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          holds_asked = 0;
   int          holds_started = 0;
   int          rsp_hold_left = 0;
   int          quiet_cycles = 0;
   int          fail_count = 0;
   logic        req_taken = 1'b0;

   // line state as the block should hold it
   logic [7:0]                    wrap_width = utfww_pkg::WIDTH_RESET;
   logic [utfww_pkg::POS_W-1:0]   at_offset = '0;
   logic [utfww_pkg::POS_W-1:0]   open_start = '0;
   logic [utfww_pkg::POS_W-1:0]   open_bytes = '0;
   logic [utfww_pkg::COL_W-1:0]   open_cols = '0;
   logic                          space_on_line = 1'b0;
   logic [utfww_pkg::POS_W-1:0]   bytes_through_space = '0;
   logic [utfww_pkg::COL_W-1:0]   cols_past_space = '0;
   logic [1:0]                    cont_to_skip = '0;
   logic [utfww_pkg::POS_W-1:0]   open_line_no = '0;

   utf8_word_wrap_line_splitter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_number  (rsp_line_number),
      .rsp_line_start   (rsp_line_start),
      .rsp_line_bytes   (rsp_line_bytes),
      .rsp_final_line   (rsp_final_line),
      .rsp_last_of_item (rsp_last_of_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int utf8_span(input logic [7:0] b);
      int span;
      span = 1;
      if (b inside {[8'hC0:8'hDF]}) begin
         span = 2;
      end else if (b inside {[8'hE0:8'hEF]}) begin
         span = 3;
      end else if (b inside {[8'hF0:8'hF7]}) begin
         span = 4;
      end
      return span;
   endfunction

   function automatic void clear_text();
      at_offset = '0;
      open_start = '0;
      open_bytes = '0;
      open_cols = '0;
      space_on_line = 1'b0;
      bytes_through_space = '0;
      cols_past_space = '0;
      cont_to_skip = '0;
      open_line_no = '0;
   endfunction

   function automatic void post_line(input logic [utfww_pkg::POS_W-1:0] start,
                                     input logic [utfww_pkg::POS_W-1:0] nbytes,
                                     input logic fin);
      utfww_pkg::record_type rec;
      rec.line_number  = open_line_no;
      rec.line_start   = start;
      rec.line_bytes   = nbytes;
      rec.final_line   = fin;
      rec.last_of_item = 1'b0;
      line_records_due.push_back(rec);
   endfunction

   function automatic void wrap_byte(input logic [7:0] b);
      int                    due_before;
      int                    span;
      int                    cols;
      logic                  pass_ended;
      utfww_pkg::record_type rec;
      due_before = line_records_due.size();
      pass_ended = 1'b0;
      if (cont_to_skip != 0) begin
         cont_to_skip = cont_to_skip - 2'd1;
      end else if (b == utfww_pkg::CHAR_NUL) begin
         post_line(open_start, open_bytes, 1'b1);
         clear_text();
         pass_ended = 1'b1;
      end else if (b == utfww_pkg::CHAR_NEWLINE) begin
         post_line(open_start, open_bytes + 13'd1, 1'b0);
         open_line_no = open_line_no + 13'd1;
         open_start = at_offset + 13'd1;
         open_bytes = '0;
         open_cols = '0;
         space_on_line = 1'b0;
         bytes_through_space = '0;
         cols_past_space = '0;
      end else begin
         span = utf8_span(b);
         // a character running past the buffer end counts as one byte
         if (at_offset + span > utfww_pkg::TEXT_BYTES)
            span = 1;
         cols = (span >= 2) ? 2 : 1;
         if (open_bytes != 0 && open_cols + cols > wrap_width) begin
            if (space_on_line) begin
               post_line(open_start, bytes_through_space, 1'b0);
               open_start = open_start + bytes_through_space;
               open_bytes = open_bytes - bytes_through_space;
               open_cols = cols_past_space;
            end else begin
               post_line(open_start, open_bytes, 1'b0);
               open_start = at_offset;
               open_bytes = '0;
               open_cols = '0;
            end
            open_line_no = open_line_no + 13'd1;
            space_on_line = 1'b0;
            bytes_through_space = '0;
            cols_past_space = '0;
         end
         open_bytes = open_bytes + utfww_pkg::POS_W'(span);
         open_cols = open_cols + utfww_pkg::COL_W'(cols);
         if (space_on_line)
            cols_past_space = cols_past_space + utfww_pkg::COL_W'(cols);
         if (b == utfww_pkg::CHAR_SPACE) begin
            space_on_line = 1'b1;
            bytes_through_space = open_bytes;
            cols_past_space = '0;
         end
         cont_to_skip = 2'(span - 1);
      end
      if (!pass_ended) begin
         at_offset = at_offset + 13'd1;
         if (at_offset >= utfww_pkg::TEXT_BYTES) begin
            post_line(open_start, open_bytes, 1'b1);
            clear_text();
         end
      end
      if (line_records_due.size() > due_before) begin
         rec = line_records_due.pop_back();
         rec.last_of_item = 1'b1;
         line_records_due.push_back(rec);
      end
   endfunction

   task automatic check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         fail_count++;
      end
   endtask

   // driver: offer the next byte once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (text_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_text_byte <= text_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold when asked
   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (holds_started != holds_asked) begin
         rsp_ready <= 1'b0;
         rsp_hold_left <= LONG_HOLD;
         holds_started <= holds_started + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // monitor: predict on each accepted byte, check each accepted record
   always @(posedge clock) begin : watch_channels
      utfww_pkg::record_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready)
            wrap_byte(req_text_byte);
         if (rsp_valid && rsp_ready) begin
            if (line_records_due.size() == 0) begin
               $error("line record %0d/%0d/%0d arrived with none pending",
                      rsp_line_number, rsp_line_start, rsp_line_bytes);
               fail_count++;
            end else begin
               want = line_records_due.pop_front();
               check_field("line_number", int'(want.line_number), int'(rsp_line_number));
               check_field("line_start", int'(want.line_start), int'(rsp_line_start));
               check_field("line_bytes", int'(want.line_bytes), int'(rsp_line_bytes));
               check_field("final_line", int'(want.final_line), int'(rsp_final_line));
               check_field("last_of_item", int'(want.last_of_item),
                           int'(rsp_last_of_item));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (text_queue.size() == 0 && !req_valid && line_records_due.size() == 0)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("utf8_word_wrap_line_splitter test failed");
            $finish;
         end
      end
   end

   task automatic set_width(input logic [7:0] w);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= w;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      wrap_width = w;
   endtask

   task automatic drain_block();
      while (text_queue.size() != 0 || req_valid || line_records_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_string(input string s);
      for (int i = 0; i < s.len(); i++)
         text_queue.push_back(s[i]);
   endtask

   // lead byte of the given span followed by some continuation bytes
   task automatic put_char(input int span, input int conts);
      case (span)
         1:       text_queue.push_back(8'($urandom_range(8'h21, 8'h7E)));
         2:       text_queue.push_back(8'($urandom_range(8'hC0, 8'hDF)));
         3:       text_queue.push_back(8'($urandom_range(8'hE0, 8'hEF)));
         default: text_queue.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      endcase
      repeat (conts) text_queue.push_back(8'($urandom_range(8'h80, 8'hBF)));
   endtask

   task automatic put_random_char();
      int r;
      int span;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         put_char(1, 0);
      end else if (r < 80) begin
         put_char(2, 1);
      end else if (r < 86) begin
         put_char(3, 2);
      end else if (r < 90) begin
         put_char(4, 3);
      end else if (r < 95) begin
         text_queue.push_back(8'($urandom_range(1, 255)));
      end else if (r < 98) begin
         // cut a character short
         span = $urandom_range(2, 4);
         put_char(span, $urandom_range(0, span - 2));
      end else begin
         // zero or newline where a continuation byte belongs
         put_char(2, 0);
         text_queue.push_back($urandom_range(0, 1) ? utfww_pkg::CHAR_NUL
                                                   : utfww_pkg::CHAR_NEWLINE);
      end
   endtask

   task automatic add_pass(input int words);
      int wl;
      int r;
      for (int w = 0; w < words; w++) begin
         wl = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 60) : $urandom_range(1, 8);
         repeat (wl) put_random_char();
         r = $urandom_range(0, 19);
         if (r < 15) begin
            text_queue.push_back(utfww_pkg::CHAR_SPACE);
         end else if (r < 17) begin
            text_queue.push_back(utfww_pkg::CHAR_NEWLINE);
         end else if (r < 19) begin
            text_queue.push_back(utfww_pkg::CHAR_SPACE);
            text_queue.push_back(utfww_pkg::CHAR_SPACE);
         end
      end
      text_queue.push_back(utfww_pkg::CHAR_NUL);
   endtask

   task automatic run_phase(input logic [7:0] w, input int idle, input int stall);
      set_width(w);
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      while (text_queue.size() < PHASE_BYTES)
         add_pass($urandom_range(1, 12));
      drain_block();
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // narrow line: word wrap, hard wrap, overwide word after a wrap, odd bytes
      set_width(8'd3);
      push_string("a bcde");
      text_queue.push_back(utfww_pkg::CHAR_NEWLINE);
      push_string(" ab");
      text_queue.push_back(8'hC3);
      text_queue.push_back(8'hA9);
      push_string("c");
      text_queue.push_back(8'hFF);
      text_queue.push_back(8'h80);
      text_queue.push_back(8'hE2);
      text_queue.push_back(utfww_pkg::CHAR_NUL);
      text_queue.push_back(utfww_pkg::CHAR_NEWLINE);
      text_queue.push_back(8'h7F);
      text_queue.push_back(utfww_pkg::CHAR_NUL);
      drain_block();

      set_width(8'd0);
      push_string("xy");
      text_queue.push_back(utfww_pkg::CHAR_NUL);
      drain_block();

      // narrow lines while the receiver holds off, so the queue fills
      set_width(8'($urandom_range(4, 12)));
      while (text_queue.size() < PHASE_BYTES)
         add_pass($urandom_range(1, 12));
      holds_asked++;
      drain_block();

      run_phase(8'd1, 0, 0);
      run_phase(8'd255, 65, 0);
      run_phase(utfww_pkg::WIDTH_RESET, 0, 65);
      run_phase(8'($urandom_range(2, 20)), 16, 16);

      if (fail_count == 0 && line_records_due.size() == 0 && !rsp_valid)
         $display("utf8_word_wrap_line_splitter test passed");
      else
         $display("utf8_word_wrap_line_splitter test failed");
      $finish;
   end

endmodule
